@@ hw/rtl/jed_pkg.sv @@
// shared types, constants and helper functions for the eight-way joystick direction block
package jed_pkg;

    // coordinate and fixed-point widths
    localparam int COORD_BITS    = 12;
    localparam int TAN_FRAC_BITS = 16;
    localparam int TAN_BITS      = TAN_FRAC_BITS + 2;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int PROD_BITS     = COORD_BITS + TAN_BITS;
    localparam int TAN_SHIFT     = 24 - TAN_FRAC_BITS;
    localparam int CFG_IDX_BITS  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_RADIUS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_RADIUS = CFG_IDX_BITS'(1);

    // reset radii, about 0.2 and 0.3 of full scale, kept squared
    localparam longint INNER_RESET = ((64'd1 << COORD_BITS) + 64'd5) / 64'd10;
    localparam longint OUTER_RESET = ((64'd3 << (COORD_BITS - 1)) + 64'd5) / 64'd10;
    localparam logic [SQ_BITS-1:0] INNER_SQ_RESET = SQ_BITS'(INNER_RESET * INNER_RESET);
    localparam logic [SQ_BITS-1:0] OUTER_SQ_RESET = SQ_BITS'(OUTER_RESET * OUTER_RESET);

    // tan(20), tan(25), tan(65), tan(70) in Q.24
    localparam logic [3:0][31:0] TAN_Q24 = {32'd46095022, 32'd35978856, 32'd7823344, 32'd6106407};

    // direction codes
    typedef enum logic [3:0] {
        DIR_NONE       = 4'd0,
        DIR_CENTER     = 4'd1,
        DIR_UP         = 4'd2,
        DIR_UP_RIGHT   = 4'd3,
        DIR_RIGHT      = 4'd4,
        DIR_DOWN_RIGHT = 4'd5,
        DIR_DOWN       = 4'd6,
        DIR_DOWN_LEFT  = 4'd7,
        DIR_LEFT       = 4'd8,
        DIR_UP_LEFT    = 4'd9
    } dir_t;

    // first stage: folded magnitudes and signs
    typedef struct packed {
        logic [COORD_BITS-1:0] p;
        logic [COORD_BITS-1:0] q;
        logic                  xneg;
        logic                  yneg;
    } mag_t;

    // second stage: squares and tangent products
    typedef struct packed {
        logic [SQ_BITS-1:0]              pp;
        logic [SQ_BITS-1:0]              qq;
        logic [COORD_BITS-1:0]           p;
        logic [3:0][PROD_BITS-1:0]       qt;
        logic                            xneg;
        logic                            yneg;
    } prod_t;

    // tangent constant with TAN_FRAC_BITS fraction bits, rounded half up
    function automatic logic [TAN_BITS-1:0] tan_const(input int k);
        logic [63:0] raw;
        logic [63:0] rnd;
        raw = 64'(TAN_Q24[k]);
        rnd = ((raw << 1) + (64'd1 << TAN_SHIFT)) >> (TAN_SHIFT + 1);
        return TAN_BITS'(rnd);
    endfunction

    // magnitude of a two's complement coordinate, full scale negative folds to 2^(n-1)
    function automatic logic [COORD_BITS-1:0] magnitude(input logic [COORD_BITS-1:0] v);
        return v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
    endfunction

endpackage

@@ hw/rtl/jed_classify.sv @@
// radius and sector decision from registered squares and tangent products
module jed_classify (
    input  jed_pkg::prod_t                     prod,
    input  logic [jed_pkg::SQ_BITS-1:0]        inner_sq,
    input  logic [jed_pkg::SQ_BITS-1:0]        outer_sq,
    output jed_pkg::dir_t                      direction
);
    import jed_pkg::*;

    logic [SQ_BITS:0]    r2;
    logic [PROD_BITS-1:0] lhs;
    logic [3:0]          gt;
    logic [3:0]          ge;

    // squared radius and scaled horizontal magnitude
    assign r2  = {1'b0, prod.pp} + {1'b0, prod.qq};
    assign lhs = PROD_BITS'(prod.p) << TAN_FRAC_BITS;

    // tangent threshold compares
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            gt[k] = lhs >  prod.qt[k];
            ge[k] = lhs >= prod.qt[k];
        end
    end

    // center test first, then outer ring sector pick per quadrant; anything else stays DIR_NONE
    always_comb
    begin
        direction = DIR_NONE;
        if (r2 < {1'b0, inner_sq})
        begin
            direction = DIR_CENTER;
        end
        else if (r2 > {1'b0, outer_sq})
        begin
            case ({prod.xneg, prod.yneg})
                2'b00:
                begin
                    if (!gt[0]) direction = DIR_UP;
                    else if (gt[1] && !gt[2]) direction = DIR_UP_RIGHT;
                    else if (gt[3]) direction = DIR_RIGHT;
                end
                2'b01:
                begin
                    if (!ge[0]) direction = DIR_DOWN;
                    else if (ge[1] && !ge[2]) direction = DIR_DOWN_RIGHT;
                    else if (ge[3]) direction = DIR_RIGHT;
                end
                2'b10:
                begin
                    if (!ge[0]) direction = DIR_UP;
                    else if (ge[1] && !ge[2]) direction = DIR_UP_LEFT;
                    else if (ge[3]) direction = DIR_LEFT;
                end
                default:
                begin
                    if (!gt[0]) direction = DIR_DOWN;
                    else if (gt[1] && !gt[2]) direction = DIR_DOWN_LEFT;
                    else if (gt[3]) direction = DIR_LEFT;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/joystick_eight_way_direction.sv @@
// top level: eight-way joystick direction classifier with round deadzone
//
//  channel  | signals                          | dir | word
//  ---------+----------------------------------+-----+---------------------------
//  in       | in_valid, in_stall, x_pos, y_pos | in  | one stick position
//  out      | out_valid, out_stall, direction  | out | one direction code
//  cfg      | cfg_valid, cfg_ready, cfg_index, | in  | radius register write
//           | cfg_data                         |     |
//
// one word accepted per cycle while in_stall is low; a taken word passes s1_reg and s2_reg before out_valid rises
// the three stages are magnitude fold, square/tangent multiply, compare and classify
// cfg is always ready; the radius is squared by one multiplier as it is written
// reset empties the pipeline and loads radii of about 0.2 and 0.3 full scale
// out_stall holds the output word; earlier words still move up into empty stages
// in_stall rises only when all stages are full
module joystick_eight_way_direction (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [jed_pkg::COORD_BITS-1:0] x_pos,
    input  logic signed [jed_pkg::COORD_BITS-1:0] y_pos,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           direction,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jed_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [jed_pkg::COORD_BITS-1:0]       cfg_data
);
    import jed_pkg::*;

    logic               s1_valid_reg;
    mag_t               s1_reg;
    mag_t               s1_next;
    logic               s2_valid_reg;
    prod_t              s2_reg;
    prod_t              s2_next;
    logic               out_valid_reg;
    dir_t               dir_reg;
    dir_t               dir_next;
    logic [SQ_BITS-1:0] inner_sq_reg;
    logic [SQ_BITS-1:0] outer_sq_reg;
    logic [SQ_BITS-1:0] cfg_sq;
    logic               out_free;
    logic               s2_free;
    logic               s1_free;

    // stall chain: a stage takes a word when it is empty or its word moves on
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;

    // configuration: radii kept squared
    assign cfg_ready = 1'b1;
    assign cfg_sq    = SQ_BITS'(cfg_data) * SQ_BITS'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_sq_reg <= INNER_SQ_RESET;
            outer_sq_reg <= OUTER_SQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INNER_RADIUS: inner_sq_reg <= cfg_sq;
                CFG_OUTER_RADIUS: outer_sq_reg <= cfg_sq;
                default: ;
            endcase
        end
    end

    // stage one: fold into the first quadrant
    always_comb
    begin
        s1_next.p    = magnitude(x_pos);
        s1_next.q    = magnitude(y_pos);
        s1_next.xneg = x_pos[COORD_BITS-1];
        s1_next.yneg = y_pos[COORD_BITS-1];
    end

    // stage two: squares and tangent products
    always_comb
    begin
        s2_next.pp   = SQ_BITS'(s1_reg.p) * SQ_BITS'(s1_reg.p);
        s2_next.qq   = SQ_BITS'(s1_reg.q) * SQ_BITS'(s1_reg.q);
        s2_next.p    = s1_reg.p;
        s2_next.xneg = s1_reg.xneg;
        s2_next.yneg = s1_reg.yneg;
        for (int k = 0; k < 4; k++)
        begin
            s2_next.qt[k] = PROD_BITS'(s1_reg.q) * PROD_BITS'(tan_const(k));
        end
    end

    // stage three: radius and sector decision
    jed_classify u_classify (
        .prod      (s2_reg),
        .inner_sq  (inner_sq_reg),
        .outer_sq  (outer_sq_reg),
        .direction (dir_next)
    );

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && out_free)
        begin
            dir_reg <= dir_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = dir_reg;

    // input is held off only when every stage holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free stage");

    // a word inside the inner radius leaves as center
    a_center: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_free &&
         (({1'b0, s2_reg.pp} + {1'b0, s2_reg.qq}) < {1'b0, inner_sq_reg}))
        |=> (dir_reg == DIR_CENTER))
        else $error("inner deadzone word not reported as center");

    // the origin never gives a direction
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_free && s2_reg.p == '0 && s2_reg.qq == '0)
        |=> (dir_reg == DIR_NONE || dir_reg == DIR_CENTER))
        else $error("origin reported a direction");

    // a word in stage two is not lost when the output stage is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_free) |=> out_valid_reg)
        else $error("stage two word dropped");

endmodule
